// ===== rtl/u8sd_pkg.sv =====
package u8sd_pkg;

    // Width of the character index counter that is kept internally.
    localparam int INDEX_BITS = 16;

    // Widths of the result fields.
    localparam int CP_W  = 31;
    localparam int IDX_W = 16;

    // Width of the count of continuation bytes still expected (0 to 5).
    localparam int REM_W = 3;

    // Largest number of continuation bytes after one lead byte.
    localparam logic [REM_W-1:0] MAX_FOLLOW = REM_W'(5);

    // The index stops at the smaller of the counter's own maximum and
    // the largest value that the result field can show.
    localparam logic [63:0] INDEX_FULL = (64'd1 << INDEX_BITS) - 64'd1;
    localparam logic [IDX_W-1:0] INDEX_LIMIT =
        (INDEX_FULL > 64'(16'hFFFF)) ? 16'hFFFF : INDEX_FULL[IDX_W-1:0];

endpackage

// ===== rtl/utf8_stream_decoder_core.sv =====
// UTF-8 stream decoder. One byte of the string is offered per request on the
// input channel, with a flag that marks the string's final byte; the block
// returns one request on the output channel for every completed character,
// carrying its code point (up to 31 bits, the legacy five- and six-byte forms
// included), its position in the string and an end-of-string flag. Bytes that
// continue a character contribute their low six bits without any check of their
// top bits, and any byte that fits no lead pattern (a stray continuation byte,
// 0xFE or 0xFF) is treated as a six-byte lead carrying a single bit. Should the
// string end part-way through a character, that character is still returned,
// with its missing bits zero and the truncated flag raised. The character index
// saturates and returns to zero after the final byte of each string. The block
// sustains one byte per clock cycle: a byte is captured in an input register,
// decoded and merged into the partial character by a single level of logic in
// the next cycle, and the finished character sits in a result register, from
// which it is offered on the output channel. The input side only stalls when
// the input register holds a byte that completes a character while the result
// register is still waiting to be taken. No clearing pass is needed after
// reset.
module utf8_stream_decoder_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_byte_value,
    input  logic                      i_last_byte,

    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [u8sd_pkg::CP_W-1:0]  o_code_point,
    output logic [u8sd_pkg::IDX_W-1:0] o_char_index,
    output logic                      o_end_of_string,
    output logic                      o_truncated
);

    // Input register: the byte waiting to be decoded.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Decoder state: the character being gathered and the string position.
    logic [u8sd_pkg::CP_W-1:0]  r_partial;
    logic [u8sd_pkg::CP_W-1:0]  n_partial;
    logic [u8sd_pkg::REM_W-1:0] r_rem;
    logic [u8sd_pkg::REM_W-1:0] n_rem;
    logic [u8sd_pkg::IDX_W-1:0] r_count;
    logic [u8sd_pkg::IDX_W-1:0] n_count;

    // Result register.
    logic                      r_out_valid;
    logic [u8sd_pkg::CP_W-1:0]  r_out_cp;
    logic [u8sd_pkg::IDX_W-1:0] r_out_idx;
    logic                      r_out_eos;
    logic                      r_out_trunc;

    // Decode of the byte held in the input register.
    logic [u8sd_pkg::REM_W-1:0] w_lead_len;
    logic [u8sd_pkg::CP_W-1:0]  w_lead_bits;
    logic [u8sd_pkg::REM_W-1:0] w_rem_dec;
    logic [u8sd_pkg::CP_W-1:0]  w_cont_bits;
    logic [u8sd_pkg::CP_W-1:0]  w_merged;
    logic [u8sd_pkg::REM_W-1:0] w_rem_next;
    logic                      w_emit;
    logic                      w_out_free;
    logic                      w_advance;
    logic                      w_in_take;

    // A lead byte sets how many continuation bytes follow and places its own
    // payload bits above the space that those bytes will fill.
    always_comb begin
        unique case (r_in_byte) inside
            8'b0???????: begin
                w_lead_len  = u8sd_pkg::REM_W'(0);
                w_lead_bits = u8sd_pkg::CP_W'(r_in_byte[6:0]);
            end
            8'b110?????: begin
                w_lead_len  = u8sd_pkg::REM_W'(1);
                w_lead_bits = u8sd_pkg::CP_W'(r_in_byte[4:0]) << 6;
            end
            8'b1110????: begin
                w_lead_len  = u8sd_pkg::REM_W'(2);
                w_lead_bits = u8sd_pkg::CP_W'(r_in_byte[3:0]) << 12;
            end
            8'b11110???: begin
                w_lead_len  = u8sd_pkg::REM_W'(3);
                w_lead_bits = u8sd_pkg::CP_W'(r_in_byte[2:0]) << 18;
            end
            8'b111110??: begin
                w_lead_len  = u8sd_pkg::REM_W'(4);
                w_lead_bits = u8sd_pkg::CP_W'(r_in_byte[1:0]) << 24;
            end
            default: begin
                // Every other byte, stray continuation bytes included, is
                // taken as a six-byte lead carrying only its lowest bit.
                w_lead_len  = u8sd_pkg::MAX_FOLLOW;
                w_lead_bits = {r_in_byte[0], 30'b0};
            end
        endcase
    end

    // A continuation byte lands at the position given by the number of bytes
    // still to come after it.
    assign w_rem_dec = r_rem - u8sd_pkg::REM_W'(1);

    always_comb begin
        case (w_rem_dec)
            3'd0:    w_cont_bits = u8sd_pkg::CP_W'(r_in_byte[5:0]);
            3'd1:    w_cont_bits = u8sd_pkg::CP_W'(r_in_byte[5:0]) << 6;
            3'd2:    w_cont_bits = u8sd_pkg::CP_W'(r_in_byte[5:0]) << 12;
            3'd3:    w_cont_bits = u8sd_pkg::CP_W'(r_in_byte[5:0]) << 18;
            default: w_cont_bits = u8sd_pkg::CP_W'(r_in_byte[5:0]) << 24;
        endcase
    end

    always_comb begin
        if (r_rem == '0) begin
            w_rem_next = w_lead_len;
            w_merged   = w_lead_bits;
        end else begin
            w_rem_next = w_rem_dec;
            w_merged   = r_partial | w_cont_bits;
        end
    end

    // A result is produced when the character is complete or the string ends.
    assign w_emit = (w_rem_next == '0) || r_in_last;

    // The held byte may move on when it produces nothing, or when the result
    // register is empty or is being emptied in this cycle.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = r_in_valid && (!w_emit || w_out_free);
    assign o_stall    = r_in_valid && !w_advance;
    assign w_in_take  = i_valid && !o_stall;

    always_comb begin
        n_partial = r_partial;
        n_rem     = r_rem;
        n_count   = r_count;
        if (w_advance) begin
            if (w_emit) begin
                n_partial = '0;
                n_rem     = '0;
                if (r_in_last) begin
                    n_count = '0;
                end else if (r_count < u8sd_pkg::INDEX_LIMIT) begin
                    n_count = r_count + u8sd_pkg::IDX_W'(1);
                end
            end else begin
                n_partial = w_merged;
                n_rem     = w_rem_next;
            end
        end
    end

    // Control and decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_partial   <= '0;
            r_rem       <= '0;
            r_count     <= '0;
        end else begin
            r_partial <= n_partial;
            r_rem     <= n_rem;
            r_count   <= n_count;
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
        if (w_advance && w_emit) begin
            r_out_cp    <= w_merged;
            r_out_idx   <= r_count;
            r_out_eos   <= r_in_last;
            r_out_trunc <= (w_rem_next != '0);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_code_point    = r_out_cp;
    assign o_char_index    = r_out_idx;
    assign o_end_of_string = r_out_eos;
    assign o_truncated     = r_out_trunc;

    // The count of expected continuation bytes never goes beyond five.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= u8sd_pkg::MAX_FOLLOW)
        else $error("continuation count out of range");

    // The character index never passes its saturation value.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= u8sd_pkg::INDEX_LIMIT)
        else $error("character index beyond its limit");

    // A truncated character is always the last one of its string.
    a_trunc_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_truncated |-> o_end_of_string)
        else $error("truncated result without end of string");

    // Once the final byte of a string moves on, the next string starts clean.
    a_string_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_last |=> (r_rem == '0) && (r_count == '0)
            && (r_partial == '0))
        else $error("state not cleared after end of string");

    // The final byte of a string always produces a result.
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_last |=> o_valid && o_end_of_string)
        else $error("final byte produced no result");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The character index stops at the smaller of the counter's own maximum
    // and the largest value that the sixteen-bit result field can carry.
    localparam logic [u8sd_pkg::IDX_W-1:0] INDEX_CAP =
        (u8sd_pkg::INDEX_BITS >= 16) ? 16'hFFFF :
        16'((64'd1 << u8sd_pkg::INDEX_BITS) - 64'd1);

    // Pacing of the run.  IDLE_LIMIT bounds how long the watchdog lets both
    // channels stay without a moving request.
    localparam int unsigned IDLE_LIMIT    = 5000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned HOLD_SPACING  = 15000;
    localparam int unsigned RANDOM_BYTES  = 1660;
    localparam int unsigned DRAIN_SPACING = 400;

    // Directed strings.  The first walks through every sequence length,
    // ending on the largest 31-bit code point and a plain
    // seven-bit character.  The second opens with 0xFE as a six-byte lead,
    // follows it with bytes whose top bits are anything but 10, and then
    // ends on a stray continuation byte, so that the last character is cut
    // short.
    localparam logic [7:0] LENGTH_WALK [22] = '{
        8'h00,
        8'hDF, 8'hBF,
        8'hEF, 8'h80, 8'h80,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'h7F
    };
    localparam logic [7:0] ODD_LEADS [7] = '{
        8'hFE, 8'h3F, 8'hC0, 8'h00, 8'hFF, 8'h7F, 8'h80
    };

    typedef struct packed {
        logic [u8sd_pkg::CP_W-1:0]  code_point;
        logic [u8sd_pkg::IDX_W-1:0] char_index;
        logic                       end_of_string;
        logic                       truncated;
    } t_char_result;

    // One byte waiting to be offered.  A byte marked drain is held back until
    // every character decoded so far has been returned.
    typedef struct {
        logic [7:0] value;
        logic       last;
        bit         drain;
    } t_byte_req;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [7:0]                 i_byte_value = 8'h00;
    logic                       i_last_byte = 1'b0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [u8sd_pkg::CP_W-1:0]  o_code_point;
    logic [u8sd_pkg::IDX_W-1:0] o_char_index;
    logic                       o_end_of_string;
    logic                       o_truncated;

    utf8_stream_decoder_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_byte_value    (i_byte_value),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_code_point    (o_code_point),
        .o_char_index    (o_char_index),
        .o_end_of_string (o_end_of_string),
        .o_truncated     (o_truncated)
    );

    t_byte_req    byte_reqs [$];
    logic [7:0]   string_buf [$];
    t_char_result expected_chars [$];

    // Decoder state as the predictor sees it.
    logic [u8sd_pkg::CP_W-1:0]  partial_char = '0;
    logic [u8sd_pkg::REM_W-1:0] follow_left = '0;
    logic [u8sd_pkg::IDX_W-1:0] next_index = '0;

    int unsigned bytes_sent = 0;
    int unsigned chars_checked = 0;
    int unsigned strings_seen = 0;
    int unsigned truncated_seen = 0;
    int unsigned capped_seen = 0;
    int unsigned long_holds = 0;
    int unsigned mismatches = 0;

    // Driver and receiver pacing state, each owned by its own process.
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned stall_mode;
    int unsigned next_hold_at;
    int unsigned idle_cycles;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Works out what one accepted byte does to the decoder and queues the
    // character that it completes, if any.  A lead byte is classified by its
    // leading ones; whatever fits no shorter pattern, stray continuation bytes
    // and 0xFE and 0xFF among them, opens a six-byte sequence with one bit.
    function automatic void decode_byte(input logic [7:0] b, input logic last_b);
        logic [u8sd_pkg::REM_W-1:0] follow;
        logic [u8sd_pkg::CP_W-1:0]  lead_bits;
        t_char_result               done;
        if (follow_left == 0) begin
            casez (b)
                8'b0???????: begin
                    follow = 3'd0;
                    lead_bits = 31'(b[6:0]);
                end
                8'b110?????: begin
                    follow = 3'd1;
                    lead_bits = 31'(b[4:0]);
                end
                8'b1110????: begin
                    follow = 3'd2;
                    lead_bits = 31'(b[3:0]);
                end
                8'b11110???: begin
                    follow = 3'd3;
                    lead_bits = 31'(b[2:0]);
                end
                8'b111110??: begin
                    follow = 3'd4;
                    lead_bits = 31'(b[1:0]);
                end
                default: begin
                    follow = u8sd_pkg::MAX_FOLLOW;
                    lead_bits = 31'(b[0]);
                end
            endcase
            partial_char = lead_bits << (6 * follow);
            follow_left = follow;
        end else begin
            // Continuation bytes give their low six bits, top bits unchecked.
            follow_left = follow_left - 3'd1;
            partial_char = partial_char | (31'(b[5:0]) << (6 * follow_left));
        end
        if (follow_left == 0 || last_b) begin
            done.code_point = partial_char;
            done.char_index = next_index;
            done.end_of_string = last_b;
            done.truncated = (follow_left != 0);
            expected_chars.push_back(done);
            if (next_index < INDEX_CAP) begin
                next_index = next_index + u8sd_pkg::IDX_W'(1);
            end
            partial_char = '0;
            follow_left = '0;
            if (last_b) begin
                next_index = '0;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 25) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (character %0d)",
                     $realtime, what, got, want, chars_checked);
        end
    endtask

    // Moves the string under construction into the request queue, marking its
    // final byte as the end of the string.
    task automatic flush_string(input bit drain);
        t_byte_req req;
        for (int i = 0; i < string_buf.size(); i++) begin
            req.value = string_buf[i];
            req.last = (i == string_buf.size() - 1);
            req.drain = drain && (i == 0);
            byte_reqs.push_back(req);
        end
        string_buf.delete();
    endtask

    // Appends one character of the given length with random payload bits.
    // Six-byte leads are the proper 0xFC and 0xFD half the time, otherwise 0xFE,
    // 0xFF or a stray continuation byte; now and then a continuation byte carries
    // random top bits.
    task automatic add_char(input int unsigned len);
        logic [7:0] lead_b;
        case (len)
            1: lead_b = {1'b0, 7'($urandom)};
            2: lead_b = {3'b110, 5'($urandom)};
            3: lead_b = {4'b1110, 4'($urandom)};
            4: lead_b = {5'b11110, 3'($urandom)};
            5: lead_b = {6'b111110, 2'($urandom)};
            default: begin
                case ($urandom_range(0, 3))
                    0, 1: lead_b = {7'b1111110, 1'($urandom)};
                    2: lead_b = {7'b1111111, 1'($urandom)};
                    default: lead_b = {2'b10, 6'($urandom)};
                endcase
            end
        endcase
        string_buf.push_back(lead_b);
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                string_buf.push_back(8'($urandom));
            end else begin
                string_buf.push_back({2'b10, 6'($urandom)});
            end
        end
    endtask

    // A random string: mostly well-formed characters of every length, with
    // the odd noise byte, and now and then cut short inside its last character.
    task automatic random_string(input int unsigned nchars, input bit drain);
        int unsigned len;
        int unsigned pick;
        int unsigned tail_len;
        tail_len = 0;
        for (int c = 0; c < nchars; c++) begin
            if ($urandom_range(0, 11) == 0) begin
                string_buf.push_back(8'($urandom));
                tail_len = 0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    len = 1;
                end else if (pick < 50) begin
                    len = 2;
                end else if (pick < 70) begin
                    len = 3;
                end else if (pick < 85) begin
                    len = 4;
                end else if (pick < 93) begin
                    len = 5;
                end else begin
                    len = 6;
                end
                add_char(len);
                tail_len = len;
            end
        end
        if (tail_len > 1 && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, tail_len - 1)) begin
                void'(string_buf.pop_back());
            end
        end
        flush_string(drain);
    endtask

    // Stimulus and end of run.  The whole stimulus is queued at time zero;
    // the driver then paces it out on its own.
    initial begin
        int unsigned random_start;
        int unsigned next_drain;
        bit          drain;

        // Directed strings, including the short ones that end inside a
        // two-byte character and on a lone 0xFF lead.
        foreach (LENGTH_WALK[i]) begin
            string_buf.push_back(LENGTH_WALK[i]);
        end
        flush_string(1'b0);
        foreach (ODD_LEADS[i]) begin
            string_buf.push_back(ODD_LEADS[i]);
        end
        flush_string(1'b0);
        string_buf.push_back(8'hC3);
        flush_string(1'b0);
        string_buf.push_back(8'hFF);
        flush_string(1'b0);

        // Random strings, the sender pausing for a full drain now and then.
        random_start = byte_reqs.size();
        next_drain = random_start;
        while (byte_reqs.size() < random_start + RANDOM_BYTES) begin
            drain = (byte_reqs.size() >= next_drain);
            if (drain) begin
                next_drain = byte_reqs.size() + DRAIN_SPACING;
            end
            if ($urandom_range(0, 9) == 0) begin
                random_string($urandom_range(20, 80), drain);
            end else begin
                random_string($urandom_range(1, 10), drain);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (byte_reqs.size() != 0 || i_valid || expected_chars.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes; %0d characters checked in %0d strings.",
                 bytes_sent, chars_checked, strings_seen);
        $display("%0d characters truncated, %0d at the index cap, %0d long receiver hold-offs.",
                 truncated_seen, capped_seen, long_holds);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Byte driver.  A request is accepted at a rising edge where i_valid is
    // high and o_stall is low; only then, or while idle, is the next byte
    // chosen, so a stalled request keeps its payload.  Bytes go out in bursts
    // of random length with random gaps, many gaps being zero.
    always @(posedge i_clk) begin : byte_driver
        t_byte_req next_req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_byte(i_byte_value, i_last_byte);
                bytes_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (byte_reqs.size() != 0 &&
                             !(byte_reqs[0].drain && expected_chars.size() != 0)) begin
                    next_req = byte_reqs.pop_front();
                    i_byte_value <= next_req.value;
                    i_last_byte <= next_req.last;
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 64);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver.  It stalls on a pattern of its own, switching between
    // no stalls and light, moderate or heavy random stalling.  At fixed
    // intervals of returned characters it holds off for a long stretch, so
    // that the block fills and pushes back on the byte channel.
    always @(posedge i_clk) begin : result_receiver
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left = 0;
            mode_left = 0;
            stall_mode = 0;
            next_hold_at = 100;
        end else if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (chars_checked >= next_hold_at) begin
            next_hold_at = next_hold_at + HOLD_SPACING;
            hold_left = HOLD_CYCLES;
            long_holds++;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            i_stall <= ($urandom_range(0, 3) < stall_mode);
        end
    end

    // Character checker.  Every accepted result is compared, field by field,
    // with the oldest predicted character.
    always @(posedge i_clk) begin : char_checker
        t_char_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected character", 32'(o_code_point), 32'd0);
            end else begin
                want = expected_chars.pop_front();
                if (o_code_point !== want.code_point) begin
                    report_mismatch("code_point", 32'(o_code_point), 32'(want.code_point));
                end
                if (o_char_index !== want.char_index) begin
                    report_mismatch("char_index", 32'(o_char_index), 32'(want.char_index));
                end
                if (o_end_of_string !== want.end_of_string) begin
                    report_mismatch("end_of_string", 32'(o_end_of_string),
                                    32'(want.end_of_string));
                end
                if (o_truncated !== want.truncated) begin
                    report_mismatch("truncated", 32'(o_truncated), 32'(want.truncated));
                end
            end
            chars_checked++;
            if (o_end_of_string) begin
                strings_seen++;
            end
            if (o_truncated) begin
                truncated_seen++;
            end
            if (o_char_index == INDEX_CAP) begin
                capped_seen++;
            end
        end
    end

    // Watchdog: the run ends if no request moves on either channel for too
    // long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no request accepted for %0d cycles, %0d characters outstanding.",
                     idle_cycles, expected_chars.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

endmodule
